[hdl/cip_pkg.sv]
// ----------------------------------------------------------------------------
// cip_pkg - shared types and helpers for the checked integer text parser
// Parse mode codes, classified character requests, result record and
// range limits per mode.
// ----------------------------------------------------------------------------
package cip_pkg;

	localparam logic [2:0] MODE_U64_DEC = 3'd0;
	localparam logic [2:0] MODE_U32_DEC = 3'd1;
	localparam logic [2:0] MODE_U32_OCT = 3'd2;
	localparam logic [2:0] MODE_I64_DEC = 3'd3;
	localparam logic [2:0] MODE_I32_DEC = 3'd4;

	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_AW    = 1;
	localparam int unsigned Q_CW    = 2;

	localparam logic [63:0] LIM_U32     = 64'h0000_0000_FFFF_FFFF;
	localparam logic [63:0] LIM_I64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LIM_I64_NEG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] LIM_I32_POS = 64'd2147483647;
	localparam logic [63:0] LIM_I32_NEG = 64'd2147483648;
	localparam logic [63:0] LIM_U64     = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		KIND_DIGIT = 3'd0,
		KIND_MINUS = 3'd1,
		KIND_PLUS  = 3'd2,
		KIND_BAD   = 3'd3,
		KIND_END   = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		logic [2:0] mode;
	} op_t;

	typedef struct packed {
		logic [63:0] value;
		logic        status;
	} res_t;

	// codes above the last mode fall back to u64 decimal
	function automatic logic [2:0] norm_mode(input logic [2:0] m);
		norm_mode = (m > MODE_I32_DEC) ? MODE_U64_DEC : m;
	endfunction

	function automatic logic is_signed_mode(input logic [2:0] m);
		is_signed_mode = (m == MODE_I64_DEC) || (m == MODE_I32_DEC);
	endfunction

	function automatic logic [63:0] mode_limit(input logic [2:0] m, input logic neg);
		case (m)
			MODE_U32_DEC, MODE_U32_OCT: mode_limit = LIM_U32;
			MODE_I64_DEC:               mode_limit = neg ? LIM_I64_NEG : LIM_I64_POS;
			MODE_I32_DEC:               mode_limit = neg ? LIM_I32_NEG : LIM_I32_POS;
			default:                    mode_limit = LIM_U64;
		endcase
	endfunction

endpackage

[hdl/cip_front.sv]
// ----------------------------------------------------------------------------
// cip_front - character classifier and request queue
// Classifies each accepted character against the current mode and holds
// the classified requests in a short queue for the accumulator.
// ----------------------------------------------------------------------------
module cip_front import cip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [2:0] parse_mode,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       is_end,
	output logic       op_valid,
	output op_t        op,
	input  logic       op_take
);

	op_t             op_mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	op_t             op_in;
	logic [2:0]      mode;
	logic            wr;
	logic            rd;
	logic            is_digit;

	always_comb begin
		mode = norm_mode(parse_mode);
		if (mode == MODE_U32_OCT) begin
			is_digit = char_code inside {[8'h30:8'h37]};
		end else begin
			is_digit = char_code inside {[8'h30:8'h39]};
		end
		op_in.mode  = mode;
		op_in.digit = char_code[3:0];
		if (is_end) begin
			op_in.kind = KIND_END;
		end else if (is_digit) begin
			op_in.kind = KIND_DIGIT;
		end else if (char_code == 8'h2D && is_signed_mode(mode)) begin
			op_in.kind = KIND_MINUS;
		end else if (char_code == 8'h2B && mode == MODE_I32_DEC) begin
			op_in.kind = KIND_PLUS;
		end else begin
			op_in.kind = KIND_BAD;
		end
	end

	assign full     = (count_q == Q_CW'(Q_DEPTH));
	assign op_valid = (count_q != '0);
	assign op       = op_mem_q[rd_ptr_q];
	assign wr       = push && !full;
	assign rd       = op_take && op_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			op_mem_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/cip_back.sv]
// ----------------------------------------------------------------------------
// cip_back - magnitude accumulator and range check
// Builds the magnitude one digit per cycle with an overflow check and
// forms the value and status on the end request.
// ----------------------------------------------------------------------------
module cip_back import cip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	input  op_t  op,
	output logic op_take,
	input  logic res_full,
	output logic res_valid,
	output res_t res
);

	logic [63:0] mag_q;
	logic        neg_q;
	logic        saw_char_q;
	logic        saw_digit_q;
	logic        failed_q;

	logic [63:0] lim;
	logic [67:0] mag_ext;
	logic [67:0] mag_next;
	logic        ovf;
	logic        bad;
	logic        is_end_op;

	assign is_end_op = (op.kind == KIND_END);
	assign op_take   = op_valid && (!is_end_op || !res_full);
	assign res_valid = op_take && is_end_op;

	always_comb begin
		lim     = mode_limit(op.mode, neg_q);
		mag_ext = {4'b0, mag_q};
		// times eight or times ten by shift and add
		if (op.mode == MODE_U32_OCT) begin
			mag_next = (mag_ext << 3) + {64'b0, op.digit};
		end else begin
			mag_next = (mag_ext << 3) + (mag_ext << 1) + {64'b0, op.digit};
		end
		ovf = mag_next > {4'b0, lim};

		bad = failed_q || !saw_digit_q || (neg_q && !is_signed_mode(op.mode))
			|| (mag_q > lim);
		res.status = bad;
		if (bad) begin
			res.value = '0;
		end else if (neg_q) begin
			res.value = ~mag_q + 64'd1;
		end else begin
			res.value = mag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q       <= '0;
			neg_q       <= 1'b0;
			saw_char_q  <= 1'b0;
			saw_digit_q <= 1'b0;
			failed_q    <= 1'b0;
		end else if (op_take) begin
			if (is_end_op) begin
				mag_q       <= '0;
				neg_q       <= 1'b0;
				saw_char_q  <= 1'b0;
				saw_digit_q <= 1'b0;
				failed_q    <= 1'b0;
			end else begin
				saw_char_q <= 1'b1;
				if (!failed_q) begin
					case (op.kind)
						KIND_DIGIT: begin
							if (ovf) begin
								failed_q <= 1'b1;
							end else begin
								mag_q       <= mag_next[63:0];
								saw_digit_q <= 1'b1;
							end
						end
						KIND_MINUS: begin
							if (saw_char_q) begin
								failed_q <= 1'b1;
							end else begin
								neg_q <= 1'b1;
							end
						end
						KIND_PLUS: begin
							if (saw_char_q) begin
								failed_q <= 1'b1;
							end
						end
						default: begin
							failed_q <= 1'b1;
						end
					endcase
				end
			end
		end
	end

endmodule

[hdl/cip_outq.sv]
// ----------------------------------------------------------------------------
// cip_outq - result queue
// Two-entry queue of finished results toward the consumer.
// ----------------------------------------------------------------------------
module cip_outq import cip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        res_valid,
	input  res_t        res,
	output logic        res_full,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] value,
	output logic        status
);

	res_t            res_mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;
	logic            wr;
	logic            rd;

	assign res_full = (count_q == Q_CW'(Q_DEPTH));
	assign empty    = (count_q == '0);
	assign wr       = res_valid && !res_full;
	assign rd       = pop && !empty;
	assign value    = res_mem_q[rd_ptr_q].value;
	assign status   = res_mem_q[rd_ptr_q].status;

	always_ff @(posedge clk) begin
		if (wr) begin
			res_mem_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/checked_integer_text_parse.sv]
// ----------------------------------------------------------------------------
// checked_integer_text_parse - checked integer text parser
// Parses one text field, a character per request, into a 64-bit value
// with a status flag, in the number format selected by parse_mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive char_code/is_end and raise push; the request is taken
//   on a clock edge with push high and full low. Send the characters of a
//   field, then one request with is_end set.
//   Result queue: while empty is low, value/status hold the oldest result;
//   pop on a clock edge with empty low takes it. Only end requests make a
//   result; status 1 means bad character, empty field, lone sign or range.
//   Throughput: one request per cycle while full is low; the accumulator's
//   multiply-by-base, add and limit compare are combinational. Path: an end
//   request waits in the request queue, its result is registered in the result queue.
//   Stall: with pop held low the two-entry result queue fills, then the
//   two-entry request queue, then full rises.
//   parse_mode_wr_en/_wr_data: write parse_mode only while idle (not enforced).
//   Reset: clears both queues, the field state and parse_mode (u64 decimal).
// ----------------------------------------------------------------------------
module checked_integer_text_parse import cip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        parse_mode_wr_en,
	input  logic [2:0]  parse_mode_wr_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic        is_end,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] value,
	output logic        status
);

	logic [2:0] parse_mode_q;
	logic       op_valid;
	op_t        op;
	logic       op_take;
	logic       res_full;
	logic       res_valid;
	res_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_mode_q <= MODE_U64_DEC;
		end else if (parse_mode_wr_en) begin
			parse_mode_q <= parse_mode_wr_data;
		end
	end

	cip_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.parse_mode (parse_mode_q),
		.push       (push),
		.full       (full),
		.char_code  (char_code),
		.is_end     (is_end),
		.op_valid   (op_valid),
		.op         (op),
		.op_take    (op_take)
	);

	cip_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.op_take   (op_take),
		.res_full  (res_full),
		.res_valid (res_valid),
		.res       (res)
	);

	cip_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_full  (res_full),
		.empty     (empty),
		.pop       (pop),
		.value     (value),
		.status    (status)
	);

`ifndef SYNTHESIS
	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status |-> value == 64'd0)
		else $error("failed parse shows a nonzero value");

	a_end_has_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !res_full)
		else $error("end request retired into a full result queue");

	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> op_valid)
		else $error("accepted request missing from request queue");
`endif

endmodule
